@@ rtl/sorted_merge_dedup_unit_macros.svh @@
// Assertion macros shared by the sorted merge and deduplication RTL.
`ifndef SORTED_MERGE_DEDUP_UNIT_MACROS_SVH
`define SORTED_MERGE_DEDUP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SMD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/smd_pkg.sv @@
// Shared constants for the sorted merge and deduplication unit.
`default_nettype none

package smd_pkg;

    localparam int CMD_W  = 2;
    localparam int DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MERGE    = 2'd2;

    localparam int DEF_LIST_DEPTH  = 16;
    localparam int DEF_VALUE_WIDTH = 32;

endpackage

`default_nettype wire

@@ rtl/sorted_merge_dedup_unit.sv @@
// Top level of the sorted merge and deduplication unit: list stores, merge walk, output register.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_cmd, i_value
//  out     | output    | o_out_valid / i_out_ready| o_value_res, o_is_last, o_empty_res,
//          |           |                          | o_overflow
//
// An append writes its list RAM at the list's fill count.
// A merge first passes through a load state that primes the RAM reads, then emits
// one word per cycle while the single output register is free to take it; the load
// state is there because the list RAMs have a registered read port.
// Reset clears the fill counts and the control state; the RAMs are not cleared.
// A stalled output holds the merge walk in place; the next word is accepted while
// the output register waits, except for an append that must report an overflow.
`default_nettype none

module sorted_merge_dedup_unit
    import smd_pkg::*;
#(
    parameter int LIST_DEPTH  = DEF_LIST_DEPTH,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [CMD_W-1:0]  i_cmd,
    input  wire logic [DATA_W-1:0] i_value,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [DATA_W-1:0] o_value_res,
    output logic                   o_is_last,
    output logic                   o_empty_res,
    output logic                   o_overflow
);

    `include "sorted_merge_dedup_unit_macros.svh"

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count_a, n_count_a;
    logic [CW-1:0] r_count_b, n_count_b;
    logic [CW-1:0] r_ia, n_ia;
    logic [CW-1:0] r_ib, n_ib;
    logic          r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_value_res, n_value_res;
    logic          r_is_last, n_is_last;
    logic          r_empty_res, n_empty_res;
    logic          r_overflow, n_overflow;

    logic [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0] q_a;
    logic [VALUE_WIDTH-1:0] q_b;
    logic [VALUE_WIDTH-1:0] sel_val;
    logic [DATA_W-1:0]      sel_out;

    logic out_free;
    logic full_a, full_b;
    logic is_app_a, is_app_b;
    logic app_full;
    logic in_acc;
    logic wr_a, wr_b;
    logic a_left, b_left;
    logic take_a, take_b;
    logic run_go;
    logic merge_last;

    // Input values are sign-extended from 32 bits, then cut to the stored width.
    generate
        if (VALUE_WIDTH <= DATA_W) begin : g_wr_narrow
            assign wdata = i_value[VALUE_WIDTH-1:0];
        end else begin : g_wr_wide
            assign wdata = {{(VALUE_WIDTH - DATA_W){i_value[DATA_W-1]}}, i_value};
        end
    endgenerate

    // Results carry the low 32 bits of the stored pattern, zero-filled when narrower.
    generate
        if (VALUE_WIDTH >= DATA_W) begin : g_rd_wide
            assign sel_out = sel_val[DATA_W-1:0];
        end else begin : g_rd_narrow
            assign sel_out = {{(DATA_W - VALUE_WIDTH){1'b0}}, sel_val};
        end
    endgenerate

    assign out_free = !r_out_valid || i_out_ready;
    assign full_a   = (r_count_a == CW'(LIST_DEPTH));
    assign full_b   = (r_count_b == CW'(LIST_DEPTH));
    assign is_app_a = (i_cmd == CMD_APPEND_A);
    assign is_app_b = (i_cmd == CMD_APPEND_B);
    assign app_full = (is_app_a && full_a) || (is_app_b && full_b);

    assign o_in_ready = (r_state == ST_IDLE) && (out_free || !app_full);
    assign in_acc     = i_in_valid && o_in_ready;
    assign wr_a       = in_acc && is_app_a && !full_a;
    assign wr_b       = in_acc && is_app_b && !full_b;

    // In the run state the RAM outputs hold the heads at r_ia and r_ib.
    assign a_left  = (r_ia < r_count_a);
    assign b_left  = (r_ib < r_count_b);
    assign take_a  = a_left && (!b_left || ($signed(q_a) <= $signed(q_b)));
    assign take_b  = b_left && (!a_left || ($signed(q_b) <= $signed(q_a)));
    assign sel_val = take_a ? q_a : q_b;
    assign run_go  = (r_state == ST_RUN) && out_free;

    always_comb begin
        n_ia = r_ia;
        n_ib = r_ib;
        if (run_go && take_a) begin
            n_ia = r_ia + CW'(1);
        end
        if (run_go && take_b) begin
            n_ib = r_ib + CW'(1);
        end
        merge_last = (n_ia >= r_count_a) && (n_ib >= r_count_b);
        if (run_go && merge_last) begin
            n_ia = '0;
            n_ib = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count_a   = r_count_a;
        n_count_b   = r_count_b;
        n_out_valid = r_out_valid && !i_out_ready;
        n_value_res = r_value_res;
        n_is_last   = r_is_last;
        n_empty_res = r_empty_res;
        n_overflow  = r_overflow;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_cmd)
                        CMD_APPEND_A, CMD_APPEND_B: begin
                            if (app_full) begin
                                n_out_valid = 1'b1;
                                n_value_res = '0;
                                n_is_last   = 1'b1;
                                n_empty_res = 1'b0;
                                n_overflow  = 1'b1;
                            end else if (is_app_a) begin
                                n_count_a = r_count_a + CW'(1);
                            end else begin
                                n_count_b = r_count_b + CW'(1);
                            end
                        end
                        CMD_MERGE: begin
                            n_state = ST_LOAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_is_last   = merge_last;
                    n_overflow  = 1'b0;
                    // Both lists empty at the start of a merge gives a single empty report.
                    n_empty_res = !a_left && !b_left;
                    n_value_res = (!a_left && !b_left) ? '0 : sel_out;
                    if (merge_last) begin
                        n_count_a = '0;
                        n_count_b = '0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count_a   <= '0;
            r_count_b   <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count_a   <= n_count_a;
            r_count_b   <= n_count_b;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value_res <= n_value_res;
        r_is_last   <= n_is_last;
        r_empty_res <= n_empty_res;
        r_overflow  <= n_overflow;
    end

    smd_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(LIST_DEPTH)
    ) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (wr_a),
        .i_waddr(r_count_a[AW-1:0]),
        .i_wdata(wdata),
        .i_raddr(n_ia[AW-1:0]),
        .o_rdata(q_a)
    );

    smd_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(LIST_DEPTH)
    ) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (wr_b),
        .i_waddr(r_count_b[AW-1:0]),
        .i_wdata(wdata),
        .i_raddr(n_ib[AW-1:0]),
        .o_rdata(q_b)
    );

    assign o_out_valid = r_out_valid;
    assign o_value_res = r_value_res;
    assign o_is_last   = r_is_last;
    assign o_empty_res = r_empty_res;
    assign o_overflow  = r_overflow;

    `SMD_ASSERT_IMPL(a_count_a_bound, 1'b1, r_count_a <= CW'(LIST_DEPTH),
                     "list A count overran")
    `SMD_ASSERT_IMPL(a_count_b_bound, 1'b1, r_count_b <= CW'(LIST_DEPTH),
                     "list B count overran")
    `SMD_ASSERT_IMPL(a_busy_not_ready, r_state != ST_IDLE, !o_in_ready,
                     "input taken during merge")
    `SMD_ASSERT_NEXT(a_merge_clears, run_go && merge_last,
                     (r_count_a == '0) && (r_count_b == '0) && (r_state == ST_IDLE),
                     "lists not cleared after merge")
    `SMD_ASSERT_IMPL(a_report_last, o_out_valid && (o_empty_res || o_overflow), o_is_last,
                     "report word not marked last")

endmodule

`default_nettype wire

@@ rtl/smd_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module smd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ bench/sorted_merge_dedup_unit_test.sv @@
// Self-checking testbench for the sorted merge and deduplication unit.
`timescale 1ns / 100ps

module sorted_merge_dedup_unit_test;
    import smd_pkg::*;

    localparam int DEPTH         = DEF_LIST_DEPTH;
    localparam int ITEM_TARGET   = 470;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [DATA_W-1:0] WORD_NEG1 = 32'hffff_ffff;
    localparam longint VAL_MIN = -64'sd2147483648;
    localparam longint VAL_MAX = 64'sd2147483647;

    typedef enum int {
        SPREAD_DENSE,
        SPREAD_WIDE,
        SPREAD_RANDOM,
        SPREAD_LOW_END,
        SPREAD_HIGH_END
    } t_spread;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        bit                wait_drain;
    } t_in_word;

    typedef struct {
        logic [DATA_W-1:0] value_res;
        logic              is_last;
        logic              empty_res;
        logic              overflow;
    } t_out_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [CMD_W-1:0]  i_cmd;
    logic [DATA_W-1:0] i_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_value_res;
    logic              o_is_last;
    logic              o_empty_res;
    logic              o_overflow;

    t_in_word  pending_words[$];
    t_out_word expected_words[$];

    // Predicted contents of the two list stores.
    logic signed [DATA_W-1:0] list_a [DEPTH];
    logic signed [DATA_W-1:0] list_b [DEPTH];
    int fill_a = 0;
    int fill_b = 0;

    int  scheduled   = 0;
    int  total_words = 0;
    int  issued      = 0;
    int  failures    = 0;
    int  quiet_cycles = 0;
    logic in_taken;

    sorted_merge_dedup_unit #(
        .LIST_DEPTH  (DEPTH),
        .VALUE_WIDTH (DATA_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value_res (o_value_res),
        .o_is_last   (o_is_last),
        .o_empty_res (o_empty_res),
        .o_overflow  (o_overflow)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Computes the result words that one accepted input word causes.
    task automatic predict_results(input logic [CMD_W-1:0] cmd,
                                   input logic [DATA_W-1:0] value);
        t_out_word w;
        int ia;
        int ib;
        bit to_a;
        logic signed [DATA_W-1:0] pick;
        w.value_res = '0;
        w.is_last   = 1'b1;
        w.empty_res = 1'b0;
        w.overflow  = 1'b0;
        case (cmd)
            CMD_APPEND_A, CMD_APPEND_B: begin
                to_a = (cmd == CMD_APPEND_A);
                if ((to_a && fill_a >= DEPTH) || (!to_a && fill_b >= DEPTH)) begin
                    w.overflow = 1'b1;
                    expected_words.push_back(w);
                end else if (to_a) begin
                    list_a[fill_a] = value;
                    fill_a++;
                end else begin
                    list_b[fill_b] = value;
                    fill_b++;
                end
            end
            CMD_MERGE: begin
                if (fill_a == 0 && fill_b == 0) begin
                    w.empty_res = 1'b1;
                    expected_words.push_back(w);
                end else begin
                    ia = 0;
                    ib = 0;
                    while (ia < fill_a || ib < fill_b) begin
                        if (ia < fill_a && ib < fill_b) begin
                            if (list_a[ia] < list_b[ib]) begin
                                pick = list_a[ia];
                                ia++;
                            end else if (list_a[ia] > list_b[ib]) begin
                                pick = list_b[ib];
                                ib++;
                            end else begin
                                // Equal heads: A's element survives, B's is dropped.
                                pick = list_a[ia];
                                ia++;
                                ib++;
                            end
                        end else if (ia < fill_a) begin
                            pick = list_a[ia];
                            ia++;
                        end else begin
                            pick = list_b[ib];
                            ib++;
                        end
                        w.value_res = pick;
                        w.is_last   = (ia == fill_a && ib == fill_b);
                        expected_words.push_back(w);
                    end
                    fill_a = 0;
                    fill_b = 0;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                              input bit wait_drain);
        t_in_word w;
        w.cmd        = cmd;
        w.value      = value;
        w.wait_drain = wait_drain;
        pending_words.push_back(w);
        if (cmd != CMD_UNUSED) begin
            scheduled++;
        end
    endtask

    function automatic int list_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return $urandom_range(0, 6);
        end
        if (r < 9) begin
            return $urandom_range(7, DEPTH);
        end
        return $urandom_range(DEPTH + 1, DEPTH + 3);
    endfunction

    task automatic start_cursor(input t_spread spread, output longint cursor);
        case (spread)
            SPREAD_DENSE:    cursor = longint'(int'($urandom_range(0, 8))) - 4;
            SPREAD_WIDE:     cursor = longint'(int'($urandom));
            SPREAD_LOW_END:  cursor = VAL_MIN + longint'($urandom_range(0, 2));
            SPREAD_HIGH_END: cursor = VAL_MAX - longint'($urandom_range(0, 20));
            default:         cursor = 0;
        endcase
    endtask

    // Ascending values with a step that suits the spread, clamped at the top; the random spread draws free values.
    task automatic next_value(input t_spread spread, inout longint cursor,
                              output logic [DATA_W-1:0] value);
        if (spread == SPREAD_RANDOM) begin
            value = $urandom;
        end else begin
            case (spread)
                SPREAD_DENSE:   cursor += longint'($urandom_range(0, 2));
                SPREAD_WIDE:    cursor += longint'($urandom_range(0, 1 << 28));
                SPREAD_LOW_END: cursor += longint'($urandom_range(0, 1));
                default:        cursor += longint'($urandom_range(0, 2));
            endcase
            if (cursor > VAL_MAX) begin
                cursor = VAL_MAX;
            end
            value = cursor[DATA_W-1:0];
        end
    endtask

    always @(negedge i_clk) begin : drive
        bit send;
        int send_idle;
        int recv_idle;
        if (i_rst_n) begin
            if (issued < total_words / 3) begin
                send_idle = 30;
                recv_idle = 74;
            end else if (issued < 2 * total_words / 3) begin
                send_idle = 74;
                recv_idle = 30;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle);
            if (!i_in_valid || in_taken) begin
                send = (pending_words.size() != 0) && ($urandom_range(0, 99) >= send_idle);
                if (send && pending_words[0].wait_drain && expected_words.size() != 0) begin
                    send = 1'b0;
                end
                if (send) begin
                    i_cmd   <= pending_words[0].cmd;
                    i_value <= pending_words[0].value;
                    void'(pending_words.pop_front());
                    issued++;
                end
                i_in_valid <= send;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_out_word want;
        bit moved;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                predict_results(i_cmd, i_value);
                moved = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                if (expected_words.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT) begin
                        $display("unexpected word: value %h last %b empty %b overflow %b",
                                 o_value_res, o_is_last, o_empty_res, o_overflow);
                    end
                end else begin
                    want = expected_words.pop_front();
                    if (o_value_res !== want.value_res || o_is_last !== want.is_last ||
                        o_empty_res !== want.empty_res || o_overflow !== want.overflow) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display("mismatch: expected value %h last %b empty %b overflow %b",
                                     want.value_res, want.is_last, want.empty_res,
                                     want.overflow);
                            $display("          actual   value %h last %b empty %b overflow %b",
                                     o_value_res, o_is_last, o_empty_res, o_overflow);
                        end
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int size_a;
        int size_b;
        int put_a;
        int put_b;
        bit to_a;
        bit first_run;
        t_spread spread_a;
        t_spread spread_b;
        longint cur_a;
        longint cur_b;
        logic [DATA_W-1:0] v;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_cmd       = CMD_APPEND_A;
        i_value     = '0;
        i_out_ready = 1'b0;
        in_taken    = 1'b0;

        // Merge with both lists empty.
        queue_word(CMD_MERGE, '0, 1'b0);
        // Extremes, equal heads across lists and a duplicate inside list B.
        queue_word(CMD_APPEND_A, WORD_MIN, 1'b0);
        queue_word(CMD_APPEND_A, WORD_NEG1, 1'b0);
        queue_word(CMD_APPEND_A, '0, 1'b0);
        queue_word(CMD_APPEND_A, WORD_MAX, 1'b0);
        queue_word(CMD_APPEND_B, WORD_MIN, 1'b0);
        queue_word(CMD_APPEND_B, '0, 1'b0);
        queue_word(CMD_APPEND_B, '0, 1'b0);
        queue_word(CMD_APPEND_B, 32'd5, 1'b0);
        queue_word(CMD_APPEND_B, WORD_MAX, 1'b0);
        queue_word(CMD_MERGE, WORD_NEG1, 1'b0);
        // The unused command must leave the lists alone.
        queue_word(CMD_UNUSED, 32'ha5a5_a5a5, 1'b0);
        // Only list A, out of order; then only list B.
        queue_word(CMD_APPEND_A, 32'd3, 1'b0);
        queue_word(CMD_APPEND_A, 32'd1, 1'b0);
        queue_word(CMD_MERGE, '0, 1'b0);
        queue_word(CMD_APPEND_B, 32'd42, 1'b0);
        queue_word(CMD_MERGE, '0, 1'b0);
        // List B runs past the end of list A.
        queue_word(CMD_APPEND_A, -32'sd5, 1'b0);
        queue_word(CMD_APPEND_B, -32'sd7, 1'b0);
        queue_word(CMD_APPEND_B, -32'sd5, 1'b0);
        queue_word(CMD_APPEND_B, 32'd9, 1'b0);
        queue_word(CMD_MERGE, '0, 1'b0);

        first_run = 1'b1;
        while (scheduled < ITEM_TARGET) begin
            size_a   = list_size();
            size_b   = list_size();
            spread_a = t_spread'($urandom_range(0, 4));
            spread_b = ($urandom_range(0, 3) == 0) ? t_spread'($urandom_range(0, 4)) : spread_a;
            start_cursor(spread_a, cur_a);
            start_cursor(spread_b, cur_b);
            put_a = 0;
            put_b = 0;
            while (put_a < size_a || put_b < size_b) begin
                if ($urandom_range(0, 24) == 0) begin
                    queue_word(CMD_UNUSED, $urandom, 1'b0);
                end
                to_a = (put_b >= size_b) || (put_a < size_a && $urandom_range(0, 1) == 1);
                if (to_a) begin
                    next_value(spread_a, cur_a, v);
                    queue_word(CMD_APPEND_A, v, 1'b0);
                    put_a++;
                end else begin
                    next_value(spread_b, cur_b, v);
                    queue_word(CMD_APPEND_B, v, 1'b0);
                    put_b++;
                end
            end
            queue_word(CMD_MERGE, $urandom, first_run || $urandom_range(0, 19) == 0);
            first_run = 1'b0;
        end
        total_words = pending_words.size();

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_in_valid || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (expected_words.size() != 0) begin
            $display("%0d expected words never arrived", expected_words.size());
            failures += expected_words.size();
        end
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/smd_pkg.sv
rtl/smd_ram.sv
rtl/sorted_merge_dedup_unit.sv
bench/sorted_merge_dedup_unit_test.sv
